@@ rtl/mbrtu_pkg.sv @@
// Shared types and constants for the Modbus RTU response checker.
// No dependencies; imported by every module of the block.
package mbrtu_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_BUSY    = 3'd0,
		ST_OK      = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_INVALID = 3'd3,
		ST_CRC     = 3'd4,
		ST_EXC     = 3'd5
	} status_t;

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_ADDR  = 8'b0000_0010,
		PH_FUNC  = 8'b0000_0100,
		PH_EXC   = 8'b0000_1000,
		PH_COUNT = 8'b0001_0000,
		PH_BODY  = 8'b0010_0000,
		PH_CRCLO = 8'b0100_0000,
		PH_CRCHI = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] rx_byte;
		logic [7:0] want_slave;
		logic [7:0] want_function;
		logic [7:0] fixed_body_len;
	} in_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       done_res;
		status_t    status;
		logic [7:0] exception_code;
	} out_t;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [7:0]  EXC_FLAG      = 8'h80;
	localparam logic [15:0] TICK_MAX      = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

endpackage

@@ rtl/mbrtu_crc16.sv @@
// Modbus CRC-16 update over one byte, reflected, eight shift steps.
// Depends on mbrtu_pkg for the polynomial.
module mbrtu_crc16 (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);
	import mbrtu_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

@@ rtl/modbus_rtu_response_checker_core.sv @@
// Top level of the Modbus RTU response checker: frame sequencer and result register.
// Depends on mbrtu_pkg and mbrtu_crc16.
//
//   channel   dir   handshake             payload
//   in        in    in_valid / in_ready   in_data  (mbrtu_pkg::in_t)
//   out       out   out_valid / out_ready out_data (mbrtu_pkg::out_t)
//   cfg       in    cfg_we                cfg_wdata (timeout in ticks)
//
// One item per cycle if out_ready is high; exactly one result per item, next cycle.
// The only storage between the two sides is the result register; in_ready is high
// whenever that register is empty or being taken in the same cycle.
// arst_n clears the phase and flags and sets the timeout register to 1000 ticks;
// the block wakes up idle.
module modbus_rtu_response_checker_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mbrtu_pkg::in_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mbrtu_pkg::out_t   out_data,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata
);
	import mbrtu_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  exp_slave_q, exp_slave_d;
	logic [7:0]  exp_func_q, exp_func_d;
	logic [7:0]  body_len_q, body_len_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [7:0]  exc_q, exc_d;
	logic [15:0] tick_q, tick_d;
	logic        exc_frame_q, exc_frame_d;
	logic        addr_bad_q, addr_bad_d;
	logic [15:0] timeout_q;
	logic        out_valid_q;
	out_t        out_data_q, res;
	logic [15:0] crc_next;
	logic [15:0] tick_inc;
	logic [7:0]  left_dec;
	logic        accept;

	mbrtu_crc16 u_crc (
		.crc_in  (crc_q),
		.data    (in_data.rx_byte),
		.crc_out (crc_next)
	);

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign tick_inc  = (tick_q != TICK_MAX) ? tick_q + 16'd1 : tick_q;
	assign left_dec  = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : bytes_left_q;

	always_comb begin
		phase_d      = phase_q;
		exp_slave_d  = exp_slave_q;
		exp_func_d   = exp_func_q;
		body_len_d   = body_len_q;
		bytes_left_d = bytes_left_q;
		crc_d        = crc_q;
		crc_lo_d     = crc_lo_q;
		exc_d        = exc_q;
		tick_d       = tick_q;
		exc_frame_d  = exc_frame_q;
		addr_bad_d   = addr_bad_q;
		res          = '0;
		case (in_data.op)
			OP_START: begin
				exp_slave_d  = in_data.want_slave;
				exp_func_d   = in_data.want_function;
				body_len_d   = in_data.fixed_body_len;
				bytes_left_d = 8'd0;
				crc_d        = CRC_INIT;
				crc_lo_d     = 8'd0;
				exc_d        = 8'd0;
				tick_d       = 16'd0;
				exc_frame_d  = 1'b0;
				addr_bad_d   = 1'b0;
				phase_d      = PH_ADDR;
			end
			OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					tick_d = tick_inc;
					if (tick_inc >= timeout_q) begin
						res.done_res = 1'b1;
						res.status   = ST_TIMEOUT;
						phase_d      = PH_IDLE;
					end
				end
			end
			OP_BYTE: begin
				unique case (phase_q)
					PH_ADDR: begin
						crc_d      = crc_next;
						addr_bad_d = (in_data.rx_byte != exp_slave_q);
						phase_d    = PH_FUNC;
					end
					PH_FUNC: begin
						crc_d  = crc_next;
						tick_d = 16'd0;
						if (addr_bad_q) begin
							res.done_res = 1'b1;
							res.status   = ST_INVALID;
							phase_d      = PH_IDLE;
						end else if (in_data.rx_byte == (exp_func_q | EXC_FLAG)) begin
							exc_frame_d = 1'b1;
							phase_d     = PH_EXC;
						end else if (in_data.rx_byte != exp_func_q) begin
							res.done_res = 1'b1;
							res.status   = ST_INVALID;
							phase_d      = PH_IDLE;
						end else if (body_len_q == 8'd0) begin
							phase_d = PH_COUNT;
						end else begin
							bytes_left_d = body_len_q;
							phase_d      = PH_BODY;
						end
					end
					PH_EXC: begin
						crc_d   = crc_next;
						exc_d   = in_data.rx_byte;
						phase_d = PH_CRCLO;
					end
					PH_COUNT: begin
						crc_d             = crc_next;
						res.payload_valid = 1'b1;
						res.payload_byte  = in_data.rx_byte;
						tick_d            = 16'd0;
						bytes_left_d      = in_data.rx_byte;
						phase_d = (in_data.rx_byte == 8'd0) ? PH_CRCLO : PH_BODY;
					end
					PH_BODY: begin
						crc_d             = crc_next;
						res.payload_valid = 1'b1;
						res.payload_byte  = in_data.rx_byte;
						bytes_left_d      = left_dec;
						if (left_dec == 8'd0) begin
							tick_d  = 16'd0;
							phase_d = PH_CRCLO;
						end
					end
					PH_CRCLO: begin
						crc_lo_d = in_data.rx_byte;
						phase_d  = PH_CRCHI;
					end
					PH_CRCHI: begin
						res.done_res = 1'b1;
						phase_d      = PH_IDLE;
						if ({in_data.rx_byte, crc_lo_q} != crc_q) begin
							res.status = ST_CRC;
						end else if (exc_frame_q) begin
							res.status         = ST_EXC;
							res.exception_code = exc_q;
						end else begin
							res.status = ST_OK;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			exp_slave_q  <= 8'd0;
			exp_func_q   <= 8'd0;
			body_len_q   <= 8'd0;
			bytes_left_q <= 8'd0;
			crc_q        <= CRC_INIT;
			crc_lo_q     <= 8'd0;
			exc_q        <= 8'd0;
			tick_q       <= 16'd0;
			exc_frame_q  <= 1'b0;
			addr_bad_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				phase_q      <= phase_d;
				exp_slave_q  <= exp_slave_d;
				exp_func_q   <= exp_func_d;
				body_len_q   <= body_len_d;
				bytes_left_q <= bytes_left_d;
				crc_q        <= crc_d;
				crc_lo_q     <= crc_lo_d;
				exc_q        <= exc_d;
				tick_q       <= tick_d;
				exc_frame_q  <= exc_frame_d;
				addr_bad_q   <= addr_bad_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// load the result register on each accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

endmodule

@@ rtl/mbrtu_checker.sv @@
// Port-level assertions for the Modbus RTU response checker, bound to the top level.
// Depends on mbrtu_pkg and modbus_rtu_response_checker_core.
module mbrtu_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  mbrtu_pkg::in_t    in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  mbrtu_pkg::out_t   out_data
);
	import mbrtu_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.op == OP_START |=> out_valid && out_data == '0)
		else $error("start transaction gave a nonzero result");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.done_res |-> out_data.status == ST_BUSY
			&& out_data.exception_code == 8'd0)
		else $error("status reported without end of transaction");

	a_done_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.payload_valid
			&& out_data.status != ST_BUSY)
		else $error("ending result carries payload or busy status");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
		else $error("payload byte set without payload_valid");

endmodule

bind modbus_rtu_response_checker_core mbrtu_checker u_mbrtu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
